// ----- hdl/cld_pkg.sv -----
// Shared constants, codes and helper functions of the content-length deframer.
package cld_pkg;

   // Default parameter values.
   localparam int LINE_CAPACITY_DEF = 256;
   localparam int LENGTH_BITS_DEF   = 31;

   // Header prefix "Content-Length:".
   localparam int PREFIX_LEN = 15;

   // Character codes.
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HT    = 8'h09;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Input opcodes.
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_BODY_START = 2'd0;
   localparam logic [1:0] KIND_BODY_BYTE  = 2'd1;
   localparam logic [1:0] KIND_CLEAN_END  = 2'd2;
   localparam logic [1:0] KIND_ERROR      = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_MALFORMED_LINE = 2'd0;
   localparam logic [1:0] ERR_MISSING_LENGTH = 2'd1;
   localparam logic [1:0] ERR_TRUNCATED_BODY = 2'd2;
   localparam logic [1:0] ERR_NONE           = 2'd3;

   // Progress through the header value.
   typedef enum logic [1:0] {
      VP_SKIP_SPACE = 2'd0,
      VP_SIGN_SEEN  = 2'd1,
      VP_DIGITS     = 2'd2,
      VP_DONE       = 2'd3
   } value_phase_type;

   // What the headers have declared so far.
   typedef enum logic [1:0] {
      DS_NONE     = 2'd0,
      DS_VALID    = 2'd1,
      DS_NEGATIVE = 2'd2
   } declared_status_type;

   // Character of the header prefix at a given position.
   function automatic logic [7:0] prefix_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h43; // C
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h4C; // L
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         4'd14:   ch = 8'h3A; // :
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Whitespace as strtol sees it: space, HT, LF, VT, FF, CR.
   function automatic logic is_space(input logic [7:0] ch);
      return (ch == CHAR_SPACE) || ((ch >= CHAR_HT) && (ch <= CHAR_CR));
   endfunction

endpackage

// ----- hdl/content_length_deframer_core.sv -----
// Top level of the content-length deframer: header parsing, body pass-through, output skid.
//
//   channel  dir  tdata (low bit up)                          tuser    tlast
//   req_     in   data_byte[7:0]                              opcode   -
//   rsp_     out  body_byte, body_length, error_code, pad     kind     last
//
// One request beat is taken per clock while req_tready is high; any result is registered.
// The per-beat work is a single registered pass over the parser state.
// Synchronous active-high reset returns the parser to the header phase of a new message.
// Results sit in an output register backed by a skid register, so req_tready is low
// only while both hold a result that the sink has not taken.
module content_length_deframer_core #(
   parameter int LINE_CAPACITY = cld_pkg::LINE_CAPACITY_DEF,
   parameter int LENGTH_BITS   = cld_pkg::LENGTH_BITS_DEF,
   localparam int RSP_DATA_W   = ((LENGTH_BITS + 10 + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // data_byte[7:0]
   input  logic                   req_tuser,   // opcode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // body_byte, body_length, error_code, zero pad
   output logic [1:0]             rsp_tuser,   // kind
   output logic                   rsp_tlast    // last
);

   localparam int LINE_W = $clog2(LINE_CAPACITY);
   localparam int PROD_W = LENGTH_BITS + 4;
   localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(LINE_CAPACITY - 1);
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

   // Parser state.
   logic                          in_body_ff, in_body_in;
   logic [LINE_W-1:0]             line_count_ff, line_count_in;
   logic                          first_was_cr_ff, first_was_cr_in;
   logic [3:0]                    prefix_pos_ff, prefix_pos_in;
   logic                          prefix_failed_ff, prefix_failed_in;
   cld_pkg::value_phase_type      value_phase_ff, value_phase_in;
   logic                          value_negative_ff, value_negative_in;
   logic [LENGTH_BITS-1:0]        value_accum_ff, value_accum_in;
   cld_pkg::declared_status_type  decl_status_ff, decl_status_in;
   logic [LENGTH_BITS-1:0]        decl_length_ff, decl_length_in;
   logic [LENGTH_BITS-1:0]        body_remaining_ff, body_remaining_in;

   // Output register and skid register.
   logic                          out_valid_ff, out_valid_in;
   logic [1:0]                    out_kind_ff, out_kind_in;
   logic [7:0]                    out_byte_ff, out_byte_in;
   logic [LENGTH_BITS-1:0]        out_len_ff, out_len_in;
   logic [1:0]                    out_err_ff, out_err_in;
   logic                          out_last_ff, out_last_in;
   logic                          skid_valid_ff, skid_valid_in;
   logic [1:0]                    skid_kind_ff, skid_kind_in;
   logic [7:0]                    skid_byte_ff, skid_byte_in;
   logic [LENGTH_BITS-1:0]        skid_len_ff, skid_len_in;
   logic [1:0]                    skid_err_ff, skid_err_in;
   logic                          skid_last_ff, skid_last_in;

   // Result of the current beat.
   logic                          accept;
   logic                          res_valid;
   logic [1:0]                    res_kind;
   logic [7:0]                    res_byte;
   logic [LENGTH_BITS-1:0]        res_len;
   logic [1:0]                    res_err;
   logic                          res_last;
   logic                          clear_line;
   logic                          clear_message;
   logic                          blank_line;
   logic                          is_digit;
   logic [PROD_W-1:0]             accum_next;
   logic [7:0]                    ch;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !skid_valid_ff;
   assign ch         = req_tdata;
   assign is_digit   = (ch >= cld_pkg::CHAR_ZERO) && (ch <= cld_pkg::CHAR_NINE);
   assign blank_line = (line_count_ff == '0)
                    || ((line_count_ff == LINE_W'(1)) && first_was_cr_ff);

   // accum * 10 + digit; any bit above the length width means saturation.
   assign accum_next = {1'b0, value_accum_ff, 3'b000} + {3'b000, value_accum_ff, 1'b0}
                     + PROD_W'(ch[3:0]);

   always_comb begin
      in_body_in        = in_body_ff;
      line_count_in     = line_count_ff;
      first_was_cr_in   = first_was_cr_ff;
      prefix_pos_in     = prefix_pos_ff;
      prefix_failed_in  = prefix_failed_ff;
      value_phase_in    = value_phase_ff;
      value_negative_in = value_negative_ff;
      value_accum_in    = value_accum_ff;
      decl_status_in    = decl_status_ff;
      decl_length_in    = decl_length_ff;
      body_remaining_in = body_remaining_ff;
      res_valid         = 1'b0;
      res_kind          = cld_pkg::KIND_BODY_BYTE;
      res_byte          = '0;
      res_len           = '0;
      res_err           = cld_pkg::ERR_NONE;
      res_last          = 1'b0;
      clear_line        = 1'b0;
      clear_message     = 1'b0;

      if (accept) begin
         if (req_tuser == cld_pkg::OP_END) begin
            res_valid     = 1'b1;
            clear_message = 1'b1;
            if (in_body_ff) begin
               res_kind = cld_pkg::KIND_ERROR;
               res_err  = cld_pkg::ERR_TRUNCATED_BODY;
            end else if (line_count_ff != '0) begin
               res_kind = cld_pkg::KIND_ERROR;
               res_err  = cld_pkg::ERR_MALFORMED_LINE;
            end else begin
               res_kind = cld_pkg::KIND_CLEAN_END;
            end
         end else if (in_body_ff) begin
            body_remaining_in = body_remaining_ff - LENGTH_BITS'(1);
            res_valid         = 1'b1;
            res_kind          = cld_pkg::KIND_BODY_BYTE;
            res_byte          = ch;
            res_last          = (body_remaining_ff == LENGTH_BITS'(1));
            clear_message     = res_last;
         end else if (ch == cld_pkg::CHAR_LF) begin
            if (!blank_line) begin
               if (!prefix_failed_ff && (prefix_pos_ff == 4'(cld_pkg::PREFIX_LEN))) begin
                  decl_length_in = value_accum_ff;
                  decl_status_in = (value_negative_ff && (value_accum_ff != '0))
                                 ? cld_pkg::DS_NEGATIVE : cld_pkg::DS_VALID;
               end
               clear_line = 1'b1;
            end else if (decl_status_ff != cld_pkg::DS_VALID) begin
               res_valid     = 1'b1;
               res_kind      = cld_pkg::KIND_ERROR;
               res_err       = cld_pkg::ERR_MISSING_LENGTH;
               clear_message = 1'b1;
            end else if (decl_length_ff == '0) begin
               res_valid     = 1'b1;
               res_kind      = cld_pkg::KIND_BODY_START;
               res_last      = 1'b1;
               clear_message = 1'b1;
            end else begin
               res_valid         = 1'b1;
               res_kind          = cld_pkg::KIND_BODY_START;
               res_len           = decl_length_ff;
               clear_line        = 1'b1;
               in_body_in        = 1'b1;
               body_remaining_in = decl_length_ff;
            end
         end else if (line_count_ff >= LINE_LIMIT) begin
            res_valid     = 1'b1;
            res_kind      = cld_pkg::KIND_ERROR;
            res_err       = cld_pkg::ERR_MALFORMED_LINE;
            clear_message = 1'b1;
         end else begin
            if (line_count_ff == '0) begin
               first_was_cr_in = (ch == cld_pkg::CHAR_CR);
            end
            if (!prefix_failed_ff) begin
               if (prefix_pos_ff < 4'(cld_pkg::PREFIX_LEN)) begin
                  if (ch == cld_pkg::prefix_char(prefix_pos_ff)) begin
                     prefix_pos_in = prefix_pos_ff + 4'd1;
                  end else begin
                     prefix_failed_in = 1'b1;
                  end
               end else if ((value_phase_ff == cld_pkg::VP_SKIP_SPACE)
                            && cld_pkg::is_space(ch)) begin
                  value_phase_in = value_phase_ff;
               end else if ((value_phase_ff == cld_pkg::VP_SKIP_SPACE)
                            && ((ch == cld_pkg::CHAR_PLUS) || (ch == cld_pkg::CHAR_MINUS))) begin
                  value_negative_in = (ch == cld_pkg::CHAR_MINUS);
                  value_phase_in    = cld_pkg::VP_SIGN_SEEN;
               end else if ((value_phase_ff != cld_pkg::VP_DONE) && is_digit) begin
                  if (value_phase_ff != cld_pkg::VP_DIGITS) begin
                     value_accum_in = LENGTH_BITS'(ch[3:0]);
                  end else if (accum_next[PROD_W-1:LENGTH_BITS] != '0) begin
                     value_accum_in = LENGTH_MAX;
                  end else begin
                     value_accum_in = accum_next[LENGTH_BITS-1:0];
                  end
                  value_phase_in = cld_pkg::VP_DIGITS;
               end else begin
                  value_phase_in = cld_pkg::VP_DONE;
               end
            end
            line_count_in = line_count_ff + LINE_W'(1);
         end
      end

      if (clear_line || clear_message) begin
         line_count_in     = '0;
         first_was_cr_in   = 1'b0;
         prefix_pos_in     = '0;
         prefix_failed_in  = 1'b0;
         value_phase_in    = cld_pkg::VP_SKIP_SPACE;
         value_negative_in = 1'b0;
         value_accum_in    = '0;
      end
      if (clear_message) begin
         in_body_in        = 1'b0;
         decl_status_in    = cld_pkg::DS_NONE;
         decl_length_in    = '0;
         body_remaining_in = '0;
      end
   end

   // Output register fed either by the skid register or by the current beat.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_byte_in   = out_byte_ff;
      out_len_in    = out_len_ff;
      out_err_in    = out_err_ff;
      out_last_in   = out_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_kind_in  = skid_kind_ff;
      skid_byte_in  = skid_byte_ff;
      skid_len_in   = skid_len_ff;
      skid_err_in   = skid_err_ff;
      skid_last_in  = skid_last_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_valid_in  = 1'b1;
            out_kind_in   = skid_kind_ff;
            out_byte_in   = skid_byte_ff;
            out_len_in    = skid_len_ff;
            out_err_in    = skid_err_ff;
            out_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_in = res_valid;
         out_kind_in  = res_kind;
         out_byte_in  = res_byte;
         out_len_in   = res_len;
         out_err_in   = res_err;
         out_last_in  = res_last;
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_kind_in  = res_kind;
         skid_byte_in  = res_byte;
         skid_len_in   = res_len;
         skid_err_in   = res_err;
         skid_last_in  = res_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff        <= 1'b0;
         line_count_ff     <= '0;
         first_was_cr_ff   <= 1'b0;
         prefix_pos_ff     <= '0;
         prefix_failed_ff  <= 1'b0;
         value_phase_ff    <= cld_pkg::VP_SKIP_SPACE;
         value_negative_ff <= 1'b0;
         value_accum_ff    <= '0;
         decl_status_ff    <= cld_pkg::DS_NONE;
         decl_length_ff    <= '0;
         body_remaining_ff <= '0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         in_body_ff        <= in_body_in;
         line_count_ff     <= line_count_in;
         first_was_cr_ff   <= first_was_cr_in;
         prefix_pos_ff     <= prefix_pos_in;
         prefix_failed_ff  <= prefix_failed_in;
         value_phase_ff    <= value_phase_in;
         value_negative_ff <= value_negative_in;
         value_accum_ff    <= value_accum_in;
         decl_status_ff    <= decl_status_in;
         decl_length_ff    <= decl_length_in;
         body_remaining_ff <= body_remaining_in;
         out_valid_ff      <= out_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_byte_ff  <= out_byte_in;
      out_len_ff   <= out_len_in;
      out_err_ff   <= out_err_in;
      out_last_ff  <= out_last_in;
      skid_kind_ff <= skid_kind_in;
      skid_byte_ff <= skid_byte_in;
      skid_len_ff  <= skid_len_in;
      skid_err_ff  <= skid_err_in;
      skid_last_ff <= skid_last_in;
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[7:0] = out_byte_ff;
      rsp_tdata[LENGTH_BITS+7:8] = out_len_ff;
      rsp_tdata[LENGTH_BITS+9:LENGTH_BITS+8] = out_err_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- tb/cld_checker.sv -----
// Checker for the content-length deframer: predicts every result beat and compares it.
module cld_checker #(
   parameter int RSP_W = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [7:0]       req_tdata,    // data_byte[7:0]
   input  logic             req_tuser,    // opcode
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,    // body_byte, body_length, error_code, zero pad
   input  logic [1:0]       rsp_tuser,    // kind
   input  logic             rsp_tlast,    // last
   output int               mismatches,
   output int               outstanding,
   output int               results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEN_W = cld_pkg::LENGTH_BITS_DEF;
   localparam longint unsigned LEN_MAX = (64'd1 << LEN_W) - 64'd1;
   localparam logic [8*cld_pkg::PREFIX_LEN-1:0] HEADER_NAME = "Content-Length:";

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       body_byte;
      logic [LEN_W-1:0] body_length;
      logic [1:0]       error_code;
      logic             last;
   } rsp_fields_type;

   rsp_fields_type awaited_rsp[$];

   // Parser state, kept apart from the block's own registers.
   bit                           in_body;
   logic [7:0]                   line_len;
   bit                           line_began_cr;
   logic [3:0]                   prefix_pos;
   bit                           prefix_miss;
   cld_pkg::value_phase_type     num_phase;
   bit                           num_minus;
   logic [LEN_W-1:0]             num_value;
   cld_pkg::declared_status_type length_state;
   logic [LEN_W-1:0]             length_value;
   logic [LEN_W-1:0]             body_left;

   function automatic bit strtol_blank(input logic [7:0] ch);
      return (ch == cld_pkg::CHAR_SPACE)
          || (ch >= cld_pkg::CHAR_HT && ch <= cld_pkg::CHAR_CR);
   endfunction

   task automatic reset_line();
      line_len      = '0;
      line_began_cr = 1'b0;
      prefix_pos    = '0;
      prefix_miss   = 1'b0;
      num_phase     = cld_pkg::VP_SKIP_SPACE;
      num_minus     = 1'b0;
      num_value     = '0;
   endtask

   task automatic reset_message();
      reset_line();
      in_body      = 1'b0;
      length_state = cld_pkg::DS_NONE;
      length_value = '0;
      body_left    = '0;
   endtask

   task automatic expect_rsp(input logic [1:0] kind, input logic [7:0] data,
                             input logic [LEN_W-1:0] len, input logic [1:0] err,
                             input logic last);
      rsp_fields_type r;
      r.kind        = kind;
      r.body_byte   = data;
      r.body_length = len;
      r.error_code  = err;
      r.last        = last;
      awaited_rsp.push_back(r);
   endtask

   // Value after the prefix: blanks, one sign, then digits saturating at the top of the range.
   task automatic take_value_char(input logic [7:0] ch);
      longint unsigned acc;
      longint unsigned dig;
      acc = num_value;
      dig = ch[3:0];
      if (num_phase == cld_pkg::VP_SKIP_SPACE && strtol_blank(ch)) begin
         num_phase = cld_pkg::VP_SKIP_SPACE;
      end else if (num_phase == cld_pkg::VP_SKIP_SPACE
                   && (ch == cld_pkg::CHAR_PLUS || ch == cld_pkg::CHAR_MINUS)) begin
         num_minus = (ch == cld_pkg::CHAR_MINUS);
         num_phase = cld_pkg::VP_SIGN_SEEN;
      end else if (num_phase != cld_pkg::VP_DONE
                   && ch >= cld_pkg::CHAR_ZERO && ch <= cld_pkg::CHAR_NINE) begin
         if (num_phase != cld_pkg::VP_DIGITS)
            acc = dig;
         else if (acc > (LEN_MAX - dig) / 10)
            acc = LEN_MAX;
         else
            acc = acc * 10 + dig;
         num_value = acc[LEN_W-1:0];
         num_phase = cld_pkg::VP_DIGITS;
      end else begin
         num_phase = cld_pkg::VP_DONE;
      end
   endtask

   task automatic advance_parser(input logic op, input logic [7:0] ch);
      if (op == cld_pkg::OP_END) begin
         if (in_body)
            expect_rsp(cld_pkg::KIND_ERROR, '0, '0, cld_pkg::ERR_TRUNCATED_BODY, 1'b0);
         else if (line_len != 0)
            expect_rsp(cld_pkg::KIND_ERROR, '0, '0, cld_pkg::ERR_MALFORMED_LINE, 1'b0);
         else
            expect_rsp(cld_pkg::KIND_CLEAN_END, '0, '0, cld_pkg::ERR_NONE, 1'b0);
         reset_message();
      end else if (in_body) begin
         body_left = body_left - 1'b1;
         if (body_left == 0) begin
            expect_rsp(cld_pkg::KIND_BODY_BYTE, ch, '0, cld_pkg::ERR_NONE, 1'b1);
            reset_message();
         end else begin
            expect_rsp(cld_pkg::KIND_BODY_BYTE, ch, '0, cld_pkg::ERR_NONE, 1'b0);
         end
      end else if (ch == cld_pkg::CHAR_LF) begin
         if (line_len == 0 || (line_len == 1 && line_began_cr)) begin
            // Blank line: the headers are over.
            if (length_state != cld_pkg::DS_VALID) begin
               expect_rsp(cld_pkg::KIND_ERROR, '0, '0, cld_pkg::ERR_MISSING_LENGTH, 1'b0);
               reset_message();
            end else if (length_value == 0) begin
               expect_rsp(cld_pkg::KIND_BODY_START, '0, '0, cld_pkg::ERR_NONE, 1'b1);
               reset_message();
            end else begin
               expect_rsp(cld_pkg::KIND_BODY_START, '0, length_value, cld_pkg::ERR_NONE,
                          1'b0);
               body_left = length_value;
               reset_line();
               in_body = 1'b1;
            end
         end else begin
            if (!prefix_miss && prefix_pos == cld_pkg::PREFIX_LEN) begin
               length_value = num_value;
               length_state = (num_minus && num_value != 0)
                            ? cld_pkg::DS_NEGATIVE : cld_pkg::DS_VALID;
            end
            reset_line();
         end
      end else if (int'(line_len) + 1 >= cld_pkg::LINE_CAPACITY_DEF) begin
         expect_rsp(cld_pkg::KIND_ERROR, '0, '0, cld_pkg::ERR_MALFORMED_LINE, 1'b0);
         reset_message();
      end else begin
         if (line_len == 0)
            line_began_cr = (ch == cld_pkg::CHAR_CR);
         if (!prefix_miss) begin
            if (prefix_pos < cld_pkg::PREFIX_LEN) begin
               if (ch == HEADER_NAME[8*(cld_pkg::PREFIX_LEN-1-prefix_pos) +: 8])
                  prefix_pos = prefix_pos + 1'b1;
               else
                  prefix_miss = 1'b1;
            end else begin
               take_value_char(ch);
            end
         end
         line_len = line_len + 1'b1;
      end
   endtask

   task automatic check_rsp();
      rsp_fields_type   want;
      logic [7:0]       got_byte;
      logic [LEN_W-1:0] got_len;
      logic [1:0]       got_err;
      got_byte = rsp_tdata[7:0];
      got_len  = rsp_tdata[8 +: LEN_W];
      got_err  = rsp_tdata[8+LEN_W +: 2];
      results_seen++;
      if (awaited_rsp.size() == 0) begin
         $error("result beat with none expected: kind %0d", rsp_tuser);
         mismatches++;
      end else begin
         want = awaited_rsp.pop_front();
         if (rsp_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
            mismatches++;
         end
         if (got_byte !== want.body_byte) begin
            $error("body_byte: expected 0x%02h, got 0x%02h", want.body_byte, got_byte);
            mismatches++;
         end
         if (got_len !== want.body_length) begin
            $error("body_length: expected %0d, got %0d", want.body_length, got_len);
            mismatches++;
         end
         if (got_err !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got_err);
            mismatches++;
         end
         if (rsp_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_tlast);
            mismatches++;
         end
      end
   endtask

   // A result beat always belongs to an earlier request beat, so it is checked first.
   always @(posedge clock) begin
      if (reset) begin
         reset_message();
         awaited_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_rsp();
         if (req_tvalid && req_tready)
            advance_parser(req_tuser, req_tdata);
      end
      outstanding <= awaited_rsp.size();
   end

endmodule

// ----- tb/tb.sv -----
// Testbench top: feeds framed byte streams to the deframer and reports the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RSP_W        = ((cld_pkg::LENGTH_BITS_DEF + 10 + 7) / 8) * 8;
   localparam int IDLE_PCT     = 32;
   localparam int DIRECTED     = 25;
   localparam int RANDOM_BEATS = 1750;
   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = '0;
   logic             req_tuser  = cld_pkg::OP_DATA;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;
   logic             rsp_tlast;

   int mismatches;
   int outstanding;
   int results_seen;
   int beats_sent    = 0;
   int messages_sent = 0;
   bit calm          = 1'b0;
   bit overlong_done = 1'b0;
   bit full_line_done = 1'b0;

   content_length_deframer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   cld_checker #(.RSP_W(RSP_W)) watcher (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .results_seen (results_seen)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == cld_pkg::CHAR_LF)
         b = 8'h7E;
      return b;
   endfunction

   function automatic logic [7:0] noisy_byte();
      if ($urandom_range(99) < 30)
         return ($urandom_range(1) != 0) ? cld_pkg::CHAR_LF : cld_pkg::CHAR_CR;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] random_blank();
      case ($urandom_range(4))
         0:       return cld_pkg::CHAR_SPACE;
         1:       return cld_pkg::CHAR_HT;
         2:       return CHAR_VT;
         3:       return CHAR_FF;
         default: return cld_pkg::CHAR_CR;
      endcase
   endfunction

   task automatic push_beat(input logic op, input logic [7:0] ch);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      beats_sent++;
      calm <= (beats_sent >= 700 && beats_sent < 950);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_beat(cld_pkg::OP_DATA, s[i]);
   endtask

   task automatic end_line();
      if ($urandom_range(1) != 0)
         push_beat(cld_pkg::OP_DATA, cld_pkg::CHAR_CR);
      push_beat(cld_pkg::OP_DATA, cld_pkg::CHAR_LF);
   endtask

   task automatic push_junk_line(input int n);
      repeat (n) push_beat(cld_pkg::OP_DATA, junk_byte());
      end_line();
   endtask

   task automatic push_length_line(input bit minus, input string digits);
      push_text("Content-Length:");
      repeat ($urandom_range(2)) push_beat(cld_pkg::OP_DATA, random_blank());
      if (minus)
         push_beat(cld_pkg::OP_DATA, cld_pkg::CHAR_MINUS);
      else if ($urandom_range(3) == 0)
         push_beat(cld_pkg::OP_DATA, cld_pkg::CHAR_PLUS);
      push_text(digits);
      // Trailing text after the digits stops the value but keeps it.
      if ($urandom_range(6) == 0)
         push_text(" x9");
      end_line();
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic send_wellformed();
      int pick;
      int body;
      int sent;
      repeat ($urandom_range(2)) push_junk_line($urandom_range(1, 12));
      // An earlier length header that the later one overrides.
      if ($urandom_range(4) == 0)
         push_length_line(1'b0, $sformatf("%0d", $urandom_range(500)));
      pick = $urandom_range(99);
      if (pick < 75) begin
         body = $urandom_range(24);
         push_length_line(1'b0, $sformatf("%0d", body));
      end else if (pick < 85) begin
         body = 0;
         push_length_line(1'b0, "");
      end else if (pick < 95) begin
         body = 1 << 30;
         if ($urandom_range(1) != 0)
            push_length_line(1'b0, "2147483647");
         else
            push_length_line(1'b0, "98765432109876");
      end else begin
         body = 0;
         push_length_line(1'b1, "0");
      end
      if ($urandom_range(3) == 0)
         push_junk_line($urandom_range(1, 6));
      end_line();
      if (body > 40)
         sent = $urandom_range(1, 6);
      else if (body > 0 && $urandom_range(9) == 0)
         sent = $urandom_range(body - 1);
      else
         sent = body;
      repeat (sent) push_beat(cld_pkg::OP_DATA, 8'($urandom_range(255)));
      if (sent < body || $urandom_range(4) == 0)
         push_beat(cld_pkg::OP_END, 8'($urandom_range(255)));
   endtask

   task automatic send_noise();
      case ($urandom_range(5))
         0: begin
            repeat ($urandom_range(1, 20)) push_beat(cld_pkg::OP_DATA, noisy_byte());
            if ($urandom_range(1) != 0)
               push_beat(cld_pkg::OP_END, 8'($urandom_range(255)));
         end
         1: begin
            push_length_line(1'b1, $sformatf("%0d", $urandom_range(1, 999)));
            end_line();
         end
         2: begin
            push_junk_line($urandom_range(1, 10));
            end_line();
         end
         3: begin
            if ($urandom_range(1) != 0)
               push_text("Content-length:");
            else
               push_text("Content-Length ");
            push_text("7");
            end_line();
            end_line();
         end
         4: begin
            repeat ($urandom_range(1, 8)) push_beat(cld_pkg::OP_DATA, junk_byte());
            push_beat(cld_pkg::OP_END, 8'($urandom_range(255)));
         end
         default: push_beat(cld_pkg::OP_END, 8'($urandom_range(255)));
      endcase
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: end at once, a CR-only blank line with no length, end inside a line,
      // and a one-byte body.
      push_beat(cld_pkg::OP_END, 8'h00);
      push_beat(cld_pkg::OP_DATA, cld_pkg::CHAR_CR);
      push_beat(cld_pkg::OP_DATA, cld_pkg::CHAR_LF);
      push_beat(cld_pkg::OP_DATA, 8'h00);
      push_beat(cld_pkg::OP_DATA, 8'hFF);
      push_beat(cld_pkg::OP_END, 8'hFF);
      push_text("Content-Length:1");
      push_beat(cld_pkg::OP_DATA, cld_pkg::CHAR_LF);
      push_beat(cld_pkg::OP_DATA, cld_pkg::CHAR_LF);
      push_beat(cld_pkg::OP_DATA, 8'hFF);
      wait_for_results();

      while (beats_sent < DIRECTED + RANDOM_BEATS) begin
         if (!overlong_done && beats_sent > 500) begin
            overlong_done = 1'b1;
            // The last byte of this run pushes the line past its capacity.
            push_beat(cld_pkg::OP_END, 8'h00);
            repeat (cld_pkg::LINE_CAPACITY_DEF) push_beat(cld_pkg::OP_DATA, junk_byte());
         end else if (!full_line_done && beats_sent > 1100) begin
            full_line_done = 1'b1;
            // The longest line that still fits.
            push_beat(cld_pkg::OP_END, 8'h00);
            repeat (cld_pkg::LINE_CAPACITY_DEF - 1)
               push_beat(cld_pkg::OP_DATA, junk_byte());
            push_beat(cld_pkg::OP_DATA, cld_pkg::CHAR_LF);
         end
         if ($urandom_range(99) < 70)
            send_wellformed();
         else
            send_noise();
         messages_sent++;
         if ($urandom_range(99) < 3)
            wait_for_results();
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      $display("Drove %0d request beats in %0d messages; checked %0d result beats.",
               beats_sent, messages_sent, results_seen);
      if (mismatches == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/cld_pkg.sv
hdl/content_length_deframer_core.sv
tb/cld_checker.sv
tb/tb.sv
